[rtl/pbeq_pkg.sv]
// shared types and constants for the pointer button event queue
`timescale 1ns / 1ps

package pbeq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);

   localparam logic KIND_TRACK = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // one queued button event
   typedef struct packed {
      logic signed [15:0] ev_x;
      logic signed [15:0] ev_y;
      logic        [4:0]  ev_buttons;
      logic        [31:0] ev_stamp;
   } event_type;

   localparam int EVENT_W = $bits(event_type);

   // datapath to controller
   typedef struct packed {
      logic ring_nonempty;
      logic pending;
      logic out_free;
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic track;
      logic read_ring;
      logic read_cur;
      logic read_none;
      logic load_fetched;
   } command_type;

endpackage

[rtl/pbeq_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module pbeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/pbeq_ctrl.sv]
// controller: accepts words and sequences ring reads
`timescale 1ns / 1ps

module pbeq_ctrl import pbeq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_kind,
   output logic        req_ready,
   input  status_type  status,
   output command_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      is_read;

   assign req_ready = (state_ff == ST_IDLE) && ((req_kind == KIND_TRACK) || status.out_free);
   assign accept    = req_valid && req_ready;
   assign is_read   = accept && (req_kind == KIND_READ);

   // a full ring always has a track since the last read, so pending covers it
   always_comb begin
      cmd.track        = accept && (req_kind == KIND_TRACK);
      cmd.read_ring    = is_read && status.pending && status.ring_nonempty;
      cmd.read_cur     = is_read && status.pending && !status.ring_nonempty;
      cmd.read_none    = is_read && !status.pending;
      cmd.load_fetched = (state_ff == ST_FETCH);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.read_ring) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/pbeq_datapath.sv]
// datapath: pointer state, ring indices, event ram and result register
`timescale 1ns / 1ps

module pbeq_datapath import pbeq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  command_type        cmd,
   output status_type         status,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic        [4:0]  req_in_buttons,
   input  logic               req_is_delta,
   input  logic        [31:0] req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_available,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic        [4:0]  rsp_out_buttons,
   output logic        [31:0] rsp_out_time
);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   logic signed [15:0] cur_x_ff, cur_y_ff;
   logic        [4:0]  cur_buttons_ff;
   logic        [31:0] cur_time_ff;
   logic [IDX_W-1:0]   wr_idx_ff, rd_idx_ff;
   logic               full_ff, pending_ff;
   logic               rsp_valid_ff, rsp_available_ff;
   event_type          rsp_event_ff;

   logic signed [15:0] new_x, new_y;
   logic               push;
   logic [IDX_W-1:0]   wr_next;
   event_type          new_event, fetched, cur_event;

   assign new_x = req_is_delta ? (cur_x_ff + req_in_x) : req_in_x;
   assign new_y = req_is_delta ? (cur_y_ff + req_in_y) : req_in_y;
   assign push  = cmd.track && !full_ff && (cur_buttons_ff != req_in_buttons);
   assign wr_next = next_slot(wr_idx_ff);

   assign new_event = '{ev_x: new_x, ev_y: new_y, ev_buttons: req_in_buttons,
                        ev_stamp: req_now_ms};
   assign cur_event = '{ev_x: cur_x_ff, ev_y: cur_y_ff, ev_buttons: cur_buttons_ff,
                        ev_stamp: cur_time_ff};

   pbeq_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_idx_ff),
      .wr_data (new_event),
      .rd_en   (cmd.read_ring),
      .rd_addr (rd_idx_ff),
      .rd_data (fetched)
   );

   always_comb begin
      status.ring_nonempty = full_ff || (rd_idx_ff != wr_idx_ff);
      status.pending       = pending_ff;
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // pointer state and ring bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         cur_buttons_ff <= '0;
         cur_time_ff    <= '0;
         wr_idx_ff      <= '0;
         rd_idx_ff      <= '0;
         full_ff        <= 1'b0;
         pending_ff     <= 1'b0;
      end else begin
         if (cmd.track) begin
            cur_x_ff       <= new_x;
            cur_y_ff       <= new_y;
            cur_buttons_ff <= req_in_buttons;
            cur_time_ff    <= req_now_ms;
            pending_ff     <= 1'b1;
            if (push) begin
               wr_idx_ff <= wr_next;
               full_ff   <= (wr_next == rd_idx_ff);
            end
         end
         if (cmd.read_ring) begin
            rd_idx_ff <= next_slot(rd_idx_ff);
         end
         if (cmd.read_ring || cmd.read_cur) begin
            full_ff    <= 1'b0;
            pending_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_fetched || cmd.read_cur || cmd.read_none) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_fetched) begin
         rsp_available_ff <= 1'b1;
         rsp_event_ff     <= fetched;
      end else if (cmd.read_cur) begin
         rsp_available_ff <= 1'b1;
         rsp_event_ff     <= cur_event;
      end else if (cmd.read_none) begin
         rsp_available_ff <= 1'b0;
         rsp_event_ff     <= '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_available   = rsp_available_ff;
   assign rsp_out_x       = rsp_event_ff.ev_x;
   assign rsp_out_y       = rsp_event_ff.ev_y;
   assign rsp_out_buttons = rsp_event_ff.ev_buttons;
   assign rsp_out_time    = rsp_event_ff.ev_stamp;

endmodule

[rtl/pointer_button_event_queue_core.sv]
// top level of the pointer button event queue
// track word: gives no result, next word may follow at once
// read word served from current state or as unavailable: result registered in the cycle after accept
// read word served from the ring: result goes through the registered ram read and the fetch
//    state into the result register; input held off while in the fetch state
// reset (synchronous, active high) clears pointer state, indices, flags and the result
//    valid flag at once; ring contents and result data are kept, with no clearing pass
`timescale 1ns / 1ps

module pointer_button_event_queue_core import pbeq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [15:0] req_in_x,
   input  logic signed [15:0] req_in_y,
   input  logic        [4:0]  req_in_buttons,
   input  logic               req_is_delta,
   input  logic        [31:0] req_now_ms,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_available,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic        [4:0]  rsp_out_buttons,
   output logic        [31:0] rsp_out_time
);

   // status up from the datapath, commands down from the controller
   status_type  status;
   command_type cmd;

   // controller decides which read path a word takes and holds off
   // the request side during the ram fetch cycle
   pbeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath keeps the pointer state, the event ring and the result register;
   // a track word may be taken while an earlier result still waits
   pbeq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_in_x        (req_in_x),
      .req_in_y        (req_in_y),
      .req_in_buttons  (req_in_buttons),
      .req_is_delta    (req_is_delta),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_available   (rsp_available),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_buttons (rsp_out_buttons),
      .rsp_out_time    (rsp_out_time)
   );

endmodule

[rtl/pbeq_checker.sv]
// port level checks for the pointer button event queue
`timescale 1ns / 1ps

module pbeq_checker import pbeq_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_available,
   input logic signed [15:0] rsp_out_x,
   input logic signed [15:0] rsp_out_y,
   input logic        [4:0]  rsp_out_buttons,
   input logic        [31:0] rsp_out_time
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_available)
         && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_buttons) && $stable(rsp_out_time))
      else $error("stalled result changed");

   // unavailable answer carries an all-zero event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_available |-> rsp_out_x == 16'sd0 && rsp_out_y == 16'sd0
         && rsp_out_buttons == 5'd0 && rsp_out_time == 32'd0)
      else $error("unavailable result with non-zero payload");

   // a track word never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_TRACK && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a track word");

   // no read taken while the result register is stuck
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_ready && req_kind == KIND_READ))
      else $error("read accepted with result register blocked");

endmodule

bind pointer_button_event_queue_core pbeq_checker u_checker (.*);
